// File: hdl/sqa_pkg.sv
package sqa_pkg;

    localparam int DivSteps = 64;

    typedef enum logic [2:0] {
        CMD_MUL = 3'd0,
        CMD_DIV = 3'd1,
        CMD_INV = 3'd2,
        CMD_REM = 3'd3,
        CMD_CMP = 3'd4
    } sqa_cmd_t;

    localparam logic [31:0] SgnBit    = 32'h8000_0000;
    localparam logic [30:0] MagMax    = 31'h7FFF_FFFF;
    localparam logic [61:0] RoundBias = 62'h8000;
    localparam logic [31:0] IntMask   = 32'hFFFF_0000;
    localparam logic [30:0] CmpMask   = 31'h7FFF_FF00;
    localparam logic [30:0] FxOne     = 31'h0001_0000;

    typedef struct packed {
        logic        is_div;
        logic        sign;
        logic        dz;
        logic [31:0] result;
        logic        eq;
        logic        ne;
        logic        lt;
        logic        gt;
    } sqa_side_t;

    typedef struct packed {
        logic [63:0] num;
        logic [30:0] den;
        logic [30:0] rem;
        logic [30:0] quo;
    } sqa_div_t;

    typedef struct packed {
        logic        is_rem;
        logic        sign;
        logic [30:0] mag_a;
        logic [30:0] mag_b;
        logic [31:0] c;
    } sqa_mul_t;

endpackage

// File: hdl/sqa_div_step.sv
module sqa_div_step
    import sqa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  sqa_div_t  in_div,
    input  sqa_side_t in_side,
    output logic      out_valid,
    output sqa_div_t  out_div,
    output sqa_side_t out_side
);

    logic      valid_reg;
    sqa_div_t  div_reg;
    sqa_div_t  div_next;
    sqa_side_t side_reg;
    logic [31:0] trial;
    logic [31:0] diff;

    always_comb begin
        trial = {in_div.rem, in_div.num[63]};
        diff  = trial - {1'b0, in_div.den};
        div_next     = in_div;
        div_next.num = {in_div.num[62:0], 1'b0};
        if (trial >= {1'b0, in_div.den}) begin
            div_next.rem = diff[30:0];
            div_next.quo = {in_div.quo[29:0], 1'b1};
        end else begin
            div_next.rem = trial[30:0];
            div_next.quo = {in_div.quo[29:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg  <= div_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// File: hdl/sqa_front.sv
module sqa_front
    import sqa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [2:0]  cmd,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic [31:0] operand_c,
    output logic        out_valid,
    output sqa_div_t    out_div,
    output sqa_side_t   out_side
);

    logic [3:0] valid_reg;
    sqa_side_t  side1_reg, side2_reg, side3_reg, side4_reg;
    sqa_div_t   div1_reg, div2_reg, div3_reg, div4_reg;
    sqa_mul_t   mul1_reg, mul2_reg, mul3_reg;
    logic [61:0] prod_reg;
    logic [31:0] mulres_reg;

    sqa_side_t  side1_next;
    sqa_side_t  side4_next;
    sqa_div_t   div1_next;
    sqa_mul_t   mul1_next;
    logic [31:0] a_int;
    logic [61:0] rounded;
    logic        na, nb;

    always_comb begin
        a_int = operand_a & IntMask;
        na    = operand_a[31];
        nb    = operand_b[31];
        side1_next = '0;
        div1_next  = '0;
        mul1_next.is_rem = 1'b0;
        mul1_next.sign   = na ^ nb;
        mul1_next.mag_a  = operand_a[30:0];
        mul1_next.mag_b  = operand_b[30:0];
        mul1_next.c      = operand_c;
        unique case (cmd)
            CMD_MUL: ;
            CMD_REM: begin
                mul1_next.is_rem = 1'b1;
                mul1_next.mag_a  = a_int[30:0];
            end
            CMD_DIV: begin
                side1_next.is_div = 1'b1;
                side1_next.sign   = na ^ nb;
                side1_next.dz     = (operand_b[30:0] == '0);
                div1_next.num     = {33'd0, operand_a[30:0]} * 64'd65536 - 64'h8000;
                div1_next.den     = operand_b[30:0];
            end
            CMD_INV: begin
                side1_next.is_div = 1'b1;
                side1_next.sign   = na;
                side1_next.dz     = (operand_a[30:0] == '0);
                div1_next.num     = {33'd0, FxOne} * 64'd65536 - 64'h8000;
                div1_next.den     = operand_a[30:0];
            end
            CMD_CMP: begin
                if (na == nb) begin
                    if ((operand_a[30:0] & CmpMask) == (operand_b[30:0] & CmpMask)) begin
                        side1_next.eq = 1'b1;
                    end else begin
                        side1_next.ne = 1'b1;
                        if (operand_a > operand_b) begin
                            side1_next.lt = na;
                            side1_next.gt = !na;
                        end else begin
                            side1_next.lt = !na;
                            side1_next.gt = na;
                        end
                    end
                end else begin
                    side1_next.ne = 1'b1;
                    side1_next.lt = na;
                    side1_next.gt = !na;
                end
            end
            default: ;
        endcase
    end

    assign rounded = prod_reg + RoundBias;

    always_comb begin
        side4_next = side3_reg;
        if (mul3_reg.is_rem) begin
            side4_next.result = mul3_reg.c - mulres_reg;
        end else if (mul3_reg.mag_a != '0 || mul3_reg.mag_b != '0 || mul3_reg.sign) begin
            side4_next.result = mulres_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side1_next;
            div1_reg  <= div1_next;
            mul1_reg  <= (cmd == CMD_MUL || cmd == CMD_REM) ? mul1_next : '0;

            side2_reg <= side1_reg;
            div2_reg  <= div1_reg;
            mul2_reg  <= mul1_reg;
            prod_reg  <= {31'd0, mul1_reg.mag_a} * {31'd0, mul1_reg.mag_b};

            side3_reg  <= side2_reg;
            div3_reg   <= div2_reg;
            mul3_reg   <= mul2_reg;
            mulres_reg <= {mul2_reg.sign, rounded[46:16]};

            side4_reg <= side4_next;
            div4_reg  <= div3_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_div   = div4_reg;
    assign out_side  = side4_reg;

endmodule

// File: hdl/signmag_q16_alu_top.sv
// channel | ports                       | tdata fields (low bit up)
// s_      | s_tvalid s_tready s_tdata   | cmd[2:0] operand_a operand_b operand_c, pad
// m_      | m_tvalid m_tready m_tdata   | result cmp_equal cmp_not_equal cmp_less
//         |                             |   cmp_greater div_zero, pad
// One beat per cycle in and out unless the output beat waits. Each beat passes a
// 4-stage front end, then the one-bit-per-stage 64-stage restoring divider.
// aresetn clears only the valid bits of every stage.
// The whole pipeline holds while the output beat waits; bubbles inside it stay.
module signmag_q16_alu_top
    import sqa_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // cmd, operand_a, operand_b, operand_c, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata    // result, eq, ne, lt, gt, div_zero, zero pad
);

    logic      en;
    logic      vv [0:DivSteps];
    sqa_div_t  dv [0:DivSteps];
    sqa_side_t sd [0:DivSteps];
    logic      out_valid_reg;
    logic [36:0] out_data_reg;
    logic [36:0] out_data_next;

    assign en       = m_tready || !out_valid_reg;
    assign s_tready = en;

    sqa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .cmd       (s_tdata[2:0]),
        .operand_a (s_tdata[34:3]),
        .operand_b (s_tdata[66:35]),
        .operand_c (s_tdata[98:67]),
        .out_valid (vv[0]),
        .out_div   (dv[0]),
        .out_side  (sd[0])
    );

    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        sqa_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vv[k]),
            .in_div    (dv[k]),
            .in_side   (sd[k]),
            .out_valid (vv[k+1]),
            .out_div   (dv[k+1]),
            .out_side  (sd[k+1])
        );
    end

    always_comb begin
        out_data_next = {1'b0, sd[DivSteps].gt, sd[DivSteps].lt, sd[DivSteps].ne,
                         sd[DivSteps].eq, sd[DivSteps].result};
        if (sd[DivSteps].is_div) begin
            out_data_next[36] = sd[DivSteps].dz;
            if (sd[DivSteps].dz) begin
                out_data_next[31:0] = {sd[DivSteps].sign, MagMax};
            end else begin
                out_data_next[31:0] = {sd[DivSteps].sign, dv[DivSteps].quo};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vv[DivSteps];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_data_reg};

    a_dz_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[36] |-> m_tdata[35:32] == 4'd0)
        else $error("div_zero with compare flags");

    a_lt_gt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[34] && m_tdata[35]) && !(m_tdata[32] && m_tdata[33]))
        else $error("conflicting compare flags");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en && vv[DivSteps] |=> vv[DivSteps])
        else $error("pipeline dropped a stalled item");

endmodule
